[hdl/lom_pkg.sv]
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and constants for the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

	localparam int IdW    = 32;
	localparam int PriceW = 20;
	localparam int QtyW   = 24;
	localparam int ArrW   = 32;

	typedef enum logic [1:0] {
		EV_TRADE   = 2'd0,
		EV_RESTED  = 2'd1,
		EV_FILLED  = 2'd2,
		EV_DROPPED = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [IdW-1:0]    id;
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   qty;
		logic              side;
	} order_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_FREE,
		ST_FINAL
	} eng_state_t;

endpackage

[hdl/lom_front.sv]
// ----------------------------------------------------------------------------
// lom_front
// Takes items and holds them in a short queue for the matching engine.
// ----------------------------------------------------------------------------
module lom_front #(
	parameter int Depth = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lom_pkg::order_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output lom_pkg::order_t head
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	lom_pkg::order_t  mem_q [Depth];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

[hdl/lom_engine.sv]
// ----------------------------------------------------------------------------
// lom_engine
// Book slots and the matching sequencer: one slot scanned per cycle.
// ----------------------------------------------------------------------------
module lom_engine #(
	parameter int MaxOrders = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        have,
	input  lom_pkg::order_t             ord,
	output logic                        take,
	output logic                        strobe,
	output logic [1:0]                  event_kind,
	output logic [lom_pkg::IdW-1:0]     taker_id,
	output logic [lom_pkg::IdW-1:0]     maker_id,
	output logic [lom_pkg::QtyW-1:0]    trade_qty,
	output logic [lom_pkg::PriceW-1:0]  trade_price,
	output logic [lom_pkg::QtyW-1:0]    left_qty,
	output logic                        last_event
);
	localparam int SW = $clog2(MaxOrders);
	localparam int CW = SW + 1;
	localparam int TW = $clog2(MaxOrders + 1);

	logic [MaxOrders-1:0]           valid_q;
	logic                           side_q  [MaxOrders];
	logic [lom_pkg::PriceW-1:0]     price_q [MaxOrders];
	logic [lom_pkg::QtyW-1:0]       qty_q   [MaxOrders];
	logic [lom_pkg::IdW-1:0]        oid_q   [MaxOrders];
	logic [lom_pkg::ArrW-1:0]       arr_q   [MaxOrders];
	logic [lom_pkg::ArrW-1:0]       arrc_q;

	lom_pkg::eng_state_t            st_q, st_d;
	lom_pkg::order_t                cur_q;
	logic [CW-1:0]                  idx_q, idx_d;
	logic [TW-1:0]                  ntr_q;
	logic                           bfound_q;
	logic [SW-1:0]                  bidx_q;
	logic [lom_pkg::PriceW-1:0]     bprice_q;
	logic [lom_pkg::ArrW-1:0]       bage_q;

	logic [SW-1:0]                  si;
	logic                           cand, better;
	logic [lom_pkg::ArrW-1:0]       age_i;
	logic [lom_pkg::QtyW-1:0]       tq, bq;

	assign si    = idx_q[SW-1:0];
	assign age_i = arrc_q - arr_q[si];
	assign cand  = valid_q[si] && (side_q[si] != cur_q.side) &&
		(cur_q.side ? (price_q[si] >= cur_q.price) : (price_q[si] <= cur_q.price));
	assign better = !bfound_q ||
		(cur_q.side ? (price_q[si] > bprice_q) : (price_q[si] < bprice_q)) ||
		((price_q[si] == bprice_q) && (age_i > bage_q));
	assign bq = qty_q[bidx_q];
	assign tq = (cur_q.qty < bq) ? cur_q.qty : bq;

	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		take  = 1'b0;
		case (st_q)
			lom_pkg::ST_IDLE: begin
				if (have) begin
					take  = 1'b1;
					idx_d = '0;
					st_d  = (ord.qty == '0) ? lom_pkg::ST_FINAL : lom_pkg::ST_SCAN;
				end
			end
			lom_pkg::ST_SCAN: begin
				idx_d = idx_q + 1'b1;
				if (idx_q == CW'(MaxOrders-1)) begin
					st_d = (bfound_q || cand) ? lom_pkg::ST_FILL : lom_pkg::ST_FREE;
					idx_d = '0;
				end
			end
			lom_pkg::ST_FILL: begin
				idx_d = '0;
				if ((cur_q.qty == tq) || (ntr_q == TW'(MaxOrders-1))) begin
					st_d = (cur_q.qty == tq) ? lom_pkg::ST_FINAL : lom_pkg::ST_FREE;
				end else begin
					st_d = lom_pkg::ST_SCAN;
				end
			end
			lom_pkg::ST_FREE: begin
				idx_d = idx_q + 1'b1;
				if (!valid_q[si] || idx_q == CW'(MaxOrders-1)) begin
					st_d = lom_pkg::ST_FINAL;
				end
			end
			lom_pkg::ST_FINAL: begin
				st_d = lom_pkg::ST_IDLE;
			end
			default: st_d = lom_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= lom_pkg::ST_IDLE;
			idx_q    <= '0;
			valid_q  <= '0;
			arrc_q   <= '0;
			ntr_q    <= '0;
			bfound_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			st_q   <= st_d;
			idx_q  <= idx_d;
			strobe <= 1'b0;
			case (st_q)
				lom_pkg::ST_IDLE: begin
					ntr_q    <= '0;
					bfound_q <= 1'b0;
				end
				lom_pkg::ST_SCAN: begin
					if (cand && better) begin
						bfound_q <= 1'b1;
					end
				end
				lom_pkg::ST_FILL: begin
					bfound_q <= 1'b0;
					ntr_q    <= ntr_q + 1'b1;
					strobe   <= 1'b1;
					if (bq == tq) begin
						valid_q[bidx_q] <= 1'b0;
					end
				end
				lom_pkg::ST_FREE: begin
					if (!valid_q[si]) begin
						valid_q[si] <= 1'b1;
						arrc_q      <= arrc_q + 1'b1;
					end
				end
				lom_pkg::ST_FINAL: begin
					strobe <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			lom_pkg::ST_IDLE: begin
				cur_q <= ord;
			end
			lom_pkg::ST_SCAN: begin
				if (cand && better) begin
					bidx_q   <= si;
					bprice_q <= price_q[si];
					bage_q   <= age_i;
				end
			end
			lom_pkg::ST_FILL: begin
				qty_q[bidx_q] <= bq - tq;
				cur_q.qty     <= cur_q.qty - tq;
				event_kind    <= lom_pkg::EV_TRADE;
				taker_id      <= cur_q.id;
				maker_id      <= oid_q[bidx_q];
				trade_qty     <= tq;
				trade_price   <= price_q[bidx_q];
				left_qty      <= cur_q.qty - tq;
				last_event    <= 1'b0;
			end
			lom_pkg::ST_FREE: begin
				event_kind <= valid_q[si] ? lom_pkg::EV_DROPPED : lom_pkg::EV_RESTED;
				if (!valid_q[si]) begin
					side_q[si]  <= cur_q.side;
					price_q[si] <= cur_q.price;
					qty_q[si]   <= cur_q.qty;
					oid_q[si]   <= cur_q.id;
					arr_q[si]   <= arrc_q;
				end
			end
			lom_pkg::ST_FINAL: begin
				taker_id    <= cur_q.id;
				maker_id    <= '0;
				trade_qty   <= '0;
				trade_price <= '0;
				left_qty    <= (cur_q.qty == '0) ? '0 : cur_q.qty;
				last_event  <= 1'b1;
				event_kind  <= (cur_q.qty == '0) ? lom_pkg::EV_FILLED : event_kind;
			end
			default: ;
		endcase
	end

endmodule

[hdl/limit_order_matcher.sv]
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority limit order book with a small input queue.
// ----------------------------------------------------------------------------
// Each item waits in the input queue until the engine loads it; the engine
// then scans the book slots in turn, with one trade step for every trade.
// Unless the order fills or reaches MAX_ORDERS trades, one more scan of the
// slots finds no match; the engine then looks for a free slot, and a final
// step gives the final result. A zero-quantity item goes straight to the
// final result. The book has a single slot scan port. busy is high while the
// two-entry queue is full. Results appear on strobe for one cycle each and
// cannot be held off; the result carrying last_event closes each order.
module limit_order_matcher #(
	parameter int MAX_ORDERS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [lom_pkg::IdW-1:0]     order_id,
	input  logic [lom_pkg::PriceW-1:0]  limit_price,
	input  logic [lom_pkg::QtyW-1:0]    order_qty,
	input  logic                        order_side,
	output logic                        strobe,
	output logic [1:0]                  event_kind,
	output logic [lom_pkg::IdW-1:0]     taker_id,
	output logic [lom_pkg::IdW-1:0]     maker_id,
	output logic [lom_pkg::QtyW-1:0]    trade_qty,
	output logic [lom_pkg::PriceW-1:0]  trade_price,
	output logic [lom_pkg::QtyW-1:0]    left_qty,
	output logic                        last_event
);
	lom_pkg::order_t in_ord, head;
	logic full, empty, take, push;

	assign in_ord = '{id: order_id, price: limit_price, qty: order_qty, side: order_side};
	assign busy   = full;
	assign push   = start && !full;

	lom_front #(.Depth(2)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(in_ord), .full(full),
		.pop(take), .empty(empty), .head(head)
	);

	lom_engine #(.MaxOrders(MAX_ORDERS)) u_engine (
		.clk(clk), .arst_n(arst_n), .have(!empty), .ord(head), .take(take),
		.strobe(strobe), .event_kind(event_kind), .taker_id(taker_id),
		.maker_id(maker_id), .trade_qty(trade_qty), .trade_price(trade_price),
		.left_qty(left_qty), .last_event(last_event)
	);

endmodule
